FILE: rtl/ewnm_pkg.sv
// Shared types and constants for the wildcard name matcher.
package ewnm_pkg;

    localparam logic [7:0] STAR_CHAR = 8'h2A;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NAME = 1'b1;

    typedef struct packed {
        logic clear;
        logic step;
        logic lead;
    } cell_ctrl_t;

endpackage

FILE: rtl/ewnm_cell.sv
// One matcher cell: one stored pattern byte and one partial-match bit.
module ewnm_cell
    import ewnm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       wr_en,
    input  logic [7:0] wr_data,
    input  logic [7:0] name_byte,
    input  logic [7:0] next_byte,
    input  logic       chain_in,
    output logic [7:0] pat_byte,
    output logic       hit,
    output logic       hit_next
);

    logic [7:0] byte_reg;
    logic       hit_reg;
    logic [7:0] cmp_byte;

    // lead mode compares against the neighbor's byte (core starts after the star)
    assign cmp_byte = ctrl.lead ? next_byte : byte_reg;
    assign hit_next = chain_in && (name_byte == cmp_byte);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            hit_reg <= hit_next;
        end
    end

    assign pat_byte = byte_reg;
    assign hit      = hit_reg;

endmodule

FILE: rtl/edge_wildcard_name_matcher_core.sv
// Wildcard name matcher top level: pattern load, cell chain, result register.
//
//  channel  | dir | tdata                        | tuser    | tlast
//  s_*      | in  | [7:0] char_value             | command  | last_byte
//  m_*      | out | [0] matched, [1] name_too_long | -      | -
//
// One item per cycle when s_tready is high; every byte updates all cells.
// A result is registered as the last name byte is taken.
// s_tready drops only while a result waits and m_tready is low.
// Reset clears lengths, positions and match bits; pattern bytes stay unknown.
module edge_wildcard_name_matcher_core
    import ewnm_pkg::*;
#(
    parameter int PATTERN_MAX = 128,
    parameter int NAME_MAX    = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_value
    input  logic       s_tuser,   // [0] command
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] name_too_long, [7:2] zero
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = $clog2(PATTERN_MAX);
    localparam int PW = $clog2(NAME_MAX + 1);
    localparam logic [LW-1:0] LEN_FULL = LW'(PATTERN_MAX);
    localparam logic [PW-1:0] POS_MAX  = PW'(NAME_MAX);

    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] load_pos_reg, load_pos_next;
    logic          trail_reg, trail_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          found_reg, found_next;
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_data_reg, m_data_next;

    logic accept, is_load, is_name, do_write, too_long, lead, wr_star;
    logic [LW-1:0] c_len, q_len, t_len, t_m1;
    logic tap_next, found_any, matched;

    cell_ctrl_t ctrl;
    logic [PATTERN_MAX-1:0] wr_en, hit, hit_nx, chain;
    logic [7:0] pat [PATTERN_MAX];
    logic [7:0] nxt [PATTERN_MAX];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_load  = accept && (s_tuser == CMD_LOAD);
    assign is_name  = accept && (s_tuser == CMD_NAME);
    assign do_write = is_load && (load_pos_reg < LEN_FULL);
    assign wr_star  = (s_tdata == STAR_CHAR);
    assign too_long = (pos_reg >= POS_MAX);

    assign lead = (len_reg != '0) && (pat[0] == STAR_CHAR);

    always_comb
    begin
        if (lead)
        begin
            if (trail_reg)
            begin
                c_len = (len_reg >= LW'(2)) ? len_reg - LW'(2) : '0;
            end
            else
            begin
                c_len = len_reg - LW'(1);
            end
        end
        else
        begin
            c_len = '0;
        end
        q_len = trail_reg ? len_reg - LW'(1) : len_reg;
        t_len = lead ? c_len : q_len;
        t_m1  = t_len - LW'(1);
    end

    assign tap_next  = (t_len != '0) && hit_nx[t_m1[IW-1:0]];
    assign found_any = found_reg || tap_next;

    always_comb
    begin
        if (too_long)
        begin
            matched = 1'b0;
        end
        else if (lead && trail_reg)
        begin
            matched = (c_len == '0) || found_any;
        end
        else if (lead)
        begin
            matched = tap_next;
        end
        else if (trail_reg)
        begin
            matched = found_any;
        end
        else
        begin
            matched = tap_next;
        end
    end

    assign ctrl.clear = is_load || (is_name && s_tlast);
    assign ctrl.step  = is_name && !s_tlast && !too_long;
    assign ctrl.lead  = lead;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            assign wr_en[k] = do_write && (load_pos_reg == LW'(k));
            if (k == 0)
            begin : g_head
                // non-lead modes start the prefix only on the first name byte
                assign chain[k] = lead || (pos_reg == '0);
            end
            else
            begin : g_body
                assign chain[k] = hit[k-1];
            end
            if (k == PATTERN_MAX - 1)
            begin : g_tail
                assign nxt[k] = 8'h00;
            end
            else
            begin : g_link
                assign nxt[k] = pat[k+1];
            end
            ewnm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .wr_en     (wr_en[k]),
                .wr_data   (s_tdata),
                .name_byte (s_tdata),
                .next_byte (nxt[k]),
                .chain_in  (chain[k]),
                .pat_byte  (pat[k]),
                .hit       (hit[k]),
                .hit_next  (hit_nx[k])
            );
        end
    endgenerate

    always_comb
    begin
        len_next      = len_reg;
        load_pos_next = load_pos_reg;
        trail_next    = trail_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        m_valid_next  = m_tready ? 1'b0 : m_valid_reg;
        m_data_next   = m_data_reg;

        if (is_load)
        begin
            pos_next   = '0;
            found_next = 1'b0;
            if (do_write)
            begin
                load_pos_next = load_pos_reg + LW'(1);
                if (s_tlast || ((len_reg != '0) && (load_pos_reg == len_reg - LW'(1))))
                begin
                    trail_next = wr_star;
                end
            end
            else if (s_tlast)
            begin
                trail_next = (pat[PATTERN_MAX-1] == STAR_CHAR);
            end
            if (s_tlast)
            begin
                len_next      = load_pos_next;
                load_pos_next = '0;
            end
        end
        else if (is_name)
        begin
            if (s_tlast)
            begin
                pos_next     = '0;
                found_next   = 1'b0;
                m_valid_next = 1'b1;
                m_data_next  = {too_long, matched};
            end
            else if (!too_long)
            begin
                pos_next   = pos_reg + PW'(1);
                found_next = found_any;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            load_pos_reg <= '0;
            trail_reg    <= 1'b0;
            pos_reg      <= '0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            load_pos_reg <= load_pos_next;
            trail_reg    <= trail_next;
            pos_reg      <= pos_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_data_reg};

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (is_name && s_tlast) |=> m_tvalid)
        else $error("name end gave no result");

    a_long_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
        else $error("overlong name reported as match");

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        is_load |=> (pos_reg == '0) && !found_reg && (hit == '0))
        else $error("pattern byte left name state");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (load_pos_reg <= LEN_FULL) && (len_reg <= LEN_FULL))
        else $error("load position beyond capacity");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("name position beyond limit");

endmodule
